@@ rtl/mtws_pkg.sv @@
package mtws_pkg;

	localparam logic [7:0] NO_HANDLE = 8'hFF;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_CHECKIN  = 2'd1,
		OP_TICK     = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_REG_SCAN,
		S_TICK_SCAN,
		S_TICK_LAST,
		S_RESP
	} state_t;

	typedef struct packed {
		logic    in_ready;
		logic    load_item;
		logic    idx_clr;
		logic    idx_inc;
		logic    reg_take;
		logic    chk_write;
		logic    clear_all;
		logic    tick_rd;
		logic    status_we;
		status_t status_set;
		logic    out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_valid;
		op_t  op;
		logic budget_zero;
		logic handle_bad;
		logic handle_used;
		logic cur_free;
		logic idx_last;
		logic out_busy;
	} dp_stat_t;

endpackage

@@ rtl/mtws_req_if.sv @@
interface mtws_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] deadline_budget;
	logic [7:0]  client_handle;
	logic [31:0] time_now;

	modport source (output valid, output operation, output deadline_budget,
		output client_handle, output time_now, input ready);
	modport sink (input valid, input operation, input deadline_budget,
		input client_handle, input time_now, output ready);
endinterface

@@ rtl/mtws_rsp_if.sv @@
interface mtws_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] handle_out;
	logic       kick_dog;

	modport source (output valid, output status, output handle_out, output kick_dog,
		input ready);
	modport sink (input valid, input status, input handle_out, input kick_dog,
		output ready);
endinterface

@@ rtl/mtws_ram.sv @@
module mtws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/mtws_ctrl.sv @@
module mtws_ctrl
	import mtws_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.status_set = ST_OK;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) begin
					cmd.load_item = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.status_we = 1'b1;
				case (stat.op)
					OP_REGISTER: begin
						if (stat.budget_zero) begin
							cmd.status_set = ST_INVALID;
							state_d = S_RESP;
						end else begin
							state_d = S_REG_SCAN;
						end
					end
					OP_CHECKIN: begin
						if (stat.handle_bad) begin
							cmd.status_set = ST_INVALID;
						end else if (!stat.handle_used) begin
							cmd.status_set = ST_NOTFOUND;
						end else begin
							cmd.chk_write = 1'b1;
						end
						state_d = S_RESP;
					end
					OP_TICK: begin
						state_d = S_TICK_SCAN;
					end
					OP_CLEAR: begin
						cmd.clear_all = 1'b1;
						state_d = S_RESP;
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_REG_SCAN: begin
				if (stat.cur_free) begin
					cmd.reg_take = 1'b1;
					cmd.status_we = 1'b1;
					cmd.status_set = ST_OK;
					state_d = S_RESP;
				end else if (stat.idx_last) begin
					cmd.status_we = 1'b1;
					cmd.status_set = ST_FULL;
					state_d = S_RESP;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_TICK_SCAN: begin
				cmd.tick_rd = 1'b1;
				if (stat.idx_last) begin
					state_d = S_TICK_LAST;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_TICK_LAST: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/mtws_dp.sv @@
module mtws_dp
	import mtws_pkg::*;
#(
	parameter int NUM_SLOTS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	mtws_req_if.sink   req,
	mtws_rsp_if.source rsp,
	input  ctl_cmd_t cmd,
	output dp_stat_t stat
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [NUM_SLOTS-1:0] in_use_q;
	logic [IW-1:0]        idx_q;
	op_t                  op_q;
	logic [31:0]          budget_q;
	logic [7:0]           handle_q;
	logic [31:0]          now_q;
	status_t              res_status_q;
	logic [7:0]           res_handle_q;
	logic                 chk_s1;
	logic                 any_q;
	logic                 alive_q;
	logic                 out_valid_q;
	status_t              rsp_status_q;
	logic [7:0]           rsp_handle_q;
	logic                 rsp_kick_q;
	logic [IW-1:0]        handle_idx;
	logic [IW-1:0]        time_waddr;
	logic                 time_we;
	logic [31:0]          budget_rd;
	logic [31:0]          last_rd;
	logic [31:0]          gap;
	logic                 overdue;

	assign handle_idx = handle_q[IW-1:0];
	assign time_we    = cmd.reg_take | cmd.chk_write;
	assign time_waddr = cmd.chk_write ? handle_idx : idx_q;
	assign gap        = now_q - last_rd;
	assign overdue    = chk_s1 & (gap > budget_rd);

	mtws_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_budget_ram (
		.clk   (clk),
		.we    (cmd.reg_take),
		.waddr (idx_q),
		.wdata (budget_q),
		.raddr (idx_q),
		.rdata (budget_rd)
	);

	mtws_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_time_ram (
		.clk   (clk),
		.we    (time_we),
		.waddr (time_waddr),
		.wdata (now_q),
		.raddr (idx_q),
		.rdata (last_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q     <= op_t'(req.operation);
			budget_q <= req.deadline_budget;
			handle_q <= req.client_handle;
			now_q    <= req.time_now;
			res_handle_q <= NO_HANDLE;
		end else if (cmd.reg_take) begin
			res_handle_q <= 8'(idx_q);
		end
		if (cmd.status_we) begin
			res_status_q <= cmd.status_set;
		end
		if (cmd.out_load) begin
			rsp_status_q <= res_status_q;
			rsp_handle_q <= res_handle_q;
			rsp_kick_q   <= (op_q == OP_TICK) & any_q & alive_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q    <= '0;
			idx_q       <= '0;
			chk_s1      <= 1'b0;
			any_q       <= 1'b0;
			alive_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_all) begin
				in_use_q <= '0;
			end else if (cmd.reg_take) begin
				in_use_q[idx_q] <= 1'b1;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			chk_s1 <= cmd.tick_rd & in_use_q[idx_q];
			if (cmd.load_item) begin
				any_q   <= 1'b0;
				alive_q <= 1'b1;
			end else begin
				any_q   <= any_q | chk_s1;
				alive_q <= alive_q & ~overdue;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req.ready = cmd.in_ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.handle_out = rsp_handle_q;
	assign rsp.kick_dog   = rsp_kick_q;

	assign stat.in_valid    = req.valid;
	assign stat.op          = op_q;
	assign stat.budget_zero = (budget_q == 32'd0);
	assign stat.handle_bad  = (handle_q >= 8'(NUM_SLOTS));
	assign stat.handle_used = in_use_q[handle_idx];
	assign stat.cur_free    = ~in_use_q[idx_q];
	assign stat.idx_last    = (idx_q == IW'(NUM_SLOTS - 1));
	assign stat.out_busy    = out_valid_q & ~rsp.ready;

	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reg_take |-> !in_use_q[idx_q])
		else $error("Registration took a slot that is already in use.");

	a_take_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reg_take |=> $countones(in_use_q) == $past($countones(in_use_q)) + 1)
		else $error("Registration did not add exactly one used slot.");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_all |=> in_use_q == '0)
		else $error("Clear left a slot in use.");

	a_kick_nohandle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_kick_q) |-> (rsp_handle_q == NO_HANDLE && rsp_status_q == ST_OK))
		else $error("A refresh result carries a handle or an error status.");

endmodule

@@ rtl/multi_task_watchdog_supervisor.sv @@
// Check-in, clear and a zero-budget register pass through the decode and response states to the output.
// Register scans the slots from index 0 and takes the lowest free one, or answers full when none is free.
// Tick reads one slot per cycle through the budget and time RAM read port.
// A new item is taken the cycle after the result enters the output register.
// Reset is asynchronous and clears all used marks; budget and time RAMs are not cleared.
module multi_task_watchdog_supervisor
	import mtws_pkg::*;
#(
	parameter int NUM_SLOTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	mtws_req_if.sink   req,
	mtws_rsp_if.source rsp
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	mtws_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	mtws_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule
